@@ src/dges_pkg.sv @@
`timescale 1ns / 1ps

package dges_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 32;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int VERT_W = 4;
    localparam int VC_W   = 5;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int DEG_W  = 6;

    // derived sizes
    localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = 2 * VERT_W;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUCC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PRED = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic [MAX_VERTICES-1:0] vset_t;

    typedef struct packed {
        logic from_hit;
        logic to_hit;
    } scan_hit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ACK,
        ST_Q_PASS1,
        ST_Q_SUM,
        ST_Q_PASS2,
        ST_Q_PRED
    } state_t;

endpackage

@@ src/dges_req_if.sv @@
`timescale 1ns / 1ps

interface dges_req_if;
    import dges_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [VERT_W-1:0] edge_source;
    logic [VERT_W-1:0] edge_dest;
    logic [VERT_W-1:0] query_vertex;

    modport source (output valid, cmd, edge_source, edge_dest, query_vertex, input ready);
    modport sink   (input valid, cmd, edge_source, edge_dest, query_vertex, output ready);
endinterface

@@ src/dges_rsp_if.sv @@
`timescale 1ns / 1ps

interface dges_rsp_if;
    import dges_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] status;
    logic [DEG_W-1:0]  out_degree;
    logic [DEG_W-1:0]  in_degree;
    logic [VERT_W-1:0] neighbour;
    logic              last;

    modport source (output valid, kind, status, out_degree, in_degree, neighbour, last,
                    input ready);
    modport sink   (input valid, kind, status, out_degree, in_degree, neighbour, last,
                    output ready);
endinterface

@@ src/dges_ram.sv @@
`timescale 1ns / 1ps

module dges_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/dges_scan_unit.sv @@
`timescale 1ns / 1ps

module dges_scan_unit (
    input  logic [dges_pkg::VERT_W-1:0] entry_from,
    input  logic [dges_pkg::VERT_W-1:0] entry_to,
    input  logic [dges_pkg::VERT_W-1:0] vertex,
    input  dges_pkg::vset_t             preds_in,
    output dges_pkg::scan_hit_t         hit,
    output dges_pkg::vset_t             preds_out
);
    import dges_pkg::*;

    localparam vset_t ONE = vset_t'(1);

    // compare one stored edge against the vertex, fold its origin into the set
    always_comb
    begin
        hit.from_hit = (entry_from == vertex);
        hit.to_hit   = (entry_to == vertex);
        preds_out    = preds_in;
        if (hit.to_hit)
        begin
            preds_out = preds_in | (ONE << entry_from);
        end
    end

endmodule

@@ src/directed_graph_edge_store.sv @@
`timescale 1ns / 1ps

// channel | dir | payload                                               | handshake
// req     | in  | cmd, edge_source, edge_dest, query_vertex             | valid/ready
// rsp     | out | kind, status, out_degree, in_degree, neighbour, last  | valid/ready
// cfg     | in  | cfg_wdata (vertex_count)                              | cfg_we, no wait
//
// add: accept, edge write with degree read, degree write, then the response
// query: two passes over the edge store
//   through one compare unit, then a walk over the predecessor set
// clear and rejected requests go straight to the response; one request at a time, ready only when idle
// reset clears the fill count and the degree valid bits; no clearing pass
// a stalled response register holds the sequencer in place, nothing is dropped

module directed_graph_edge_store (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [dges_pkg::VC_W-1:0] cfg_wdata,
    dges_req_if.sink                 req,
    dges_rsp_if.source               rsp
);
    import dges_pkg::*;

    localparam vset_t ONE = vset_t'(1);

    // control and request registers
    state_t              state_reg,      state_next;
    logic [VC_W-1:0]     vc_reg;
    logic [CNT_W-1:0]    held_reg,       held_next;
    vset_t               vld_out_reg,    vld_out_next;
    vset_t               vld_in_reg,     vld_in_next;
    logic [VERT_W-1:0]   src_reg,        src_next;
    logic [VERT_W-1:0]   dst_reg,        dst_next;
    logic [VERT_W-1:0]   q_reg,          q_next;
    logic [KIND_W-1:0]   ack_kind_reg,   ack_kind_next;
    logic [STAT_W-1:0]   ack_status_reg, ack_status_next;
    logic [CNT_W-1:0]    rem_reg,        rem_next;
    logic                pend_reg,       pend_next;
    logic [CNT_W-1:0]    sc_reg,         sc_next;
    vset_t               preds_reg,      preds_next;
    logic [VIDX_W-1:0]   pidx_reg,       pidx_next;

    // response register
    logic                rv_reg,         rv_next;
    logic [KIND_W-1:0]   kind_reg,       kind_next;
    logic [STAT_W-1:0]   status_reg,     status_next;
    logic [DEG_W-1:0]    odeg_reg,       odeg_next;
    logic [DEG_W-1:0]    ideg_reg,       ideg_next;
    logic [VERT_W-1:0]   nb_reg,         nb_next;
    logic                last_reg,       last_next;

    // memory ports
    logic                edge_we, edge_re;
    logic [EIDX_W-1:0]   edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]   edge_wdata, edge_rdata;
    logic                deg_re, deg_we;
    logic [VIDX_W-1:0]   dego_waddr, degi_waddr, dego_raddr, degi_raddr;
    logic [DEG_W-1:0]    dego_wdata, degi_wdata, dego_rdata, degi_rdata;

    // shared compare unit
    scan_hit_t           hit;
    vset_t               preds_scan;

    // misc
    logic [VC_W-1:0]     lim;
    logic                accept;
    logic                slot_free;
    logic [CNT_W-1:0]    rem_m1;
    logic [DEG_W-1:0]    q_odeg, q_ideg;
    vset_t               preds_rest;
    logic                emit;
    logic [KIND_W-1:0]   e_kind;
    logic [STAT_W-1:0]   e_status;
    logic [DEG_W-1:0]    e_odeg, e_ideg;
    logic [VERT_W-1:0]   e_nb;
    logic                e_last;

    // edge store: origin in the upper nibble, destination in the lower
    dges_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // out-degree and in-degree tables, entries qualified by valid bits
    dges_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_dego_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (dego_waddr),
        .wdata (dego_wdata),
        .re    (deg_re),
        .raddr (dego_raddr),
        .rdata (dego_rdata)
    );

    dges_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_degi_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (degi_waddr),
        .wdata (degi_wdata),
        .re    (deg_re),
        .raddr (degi_raddr),
        .rdata (degi_rdata)
    );

    dges_scan_unit u_scan (
        .entry_from (edge_rdata[EDGE_W-1:VERT_W]),
        .entry_to   (edge_rdata[VERT_W-1:0]),
        .vertex     (q_reg),
        .preds_in   (preds_reg),
        .hit        (hit),
        .preds_out  (preds_scan)
    );

    // vertex limit saturates at the table size
    assign lim = (vc_reg > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vc_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !rv_reg || rsp.ready;
    assign rem_m1    = rem_reg - 1'b1;

    // degrees of the queried vertex, zero where never counted since clear
    assign q_odeg = vld_out_reg[q_reg[VIDX_W-1:0]] ? dego_rdata : '0;
    assign q_ideg = vld_in_reg[q_reg[VIDX_W-1:0]]  ? degi_rdata : '0;

    assign preds_rest = preds_reg & ~(ONE << pidx_reg);

    // memory addressing
    assign edge_waddr = held_reg[EIDX_W-1:0];
    assign edge_wdata = {src_reg, dst_reg};
    assign edge_raddr = rem_m1[EIDX_W-1:0];
    assign dego_raddr = (state_reg == ST_ADD_RD) ? src_reg[VIDX_W-1:0] : q_reg[VIDX_W-1:0];
    assign degi_raddr = (state_reg == ST_ADD_RD) ? dst_reg[VIDX_W-1:0] : q_reg[VIDX_W-1:0];
    assign dego_waddr = src_reg[VIDX_W-1:0];
    assign degi_waddr = dst_reg[VIDX_W-1:0];
    assign dego_wdata = vld_out_reg[src_reg[VIDX_W-1:0]] ? dego_rdata + 1'b1 : DEG_W'(1);
    assign degi_wdata = vld_in_reg[dst_reg[VIDX_W-1:0]]  ? degi_rdata + 1'b1 : DEG_W'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        vld_out_next    = vld_out_reg;
        vld_in_next     = vld_in_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        q_next          = q_reg;
        ack_kind_next   = ack_kind_reg;
        ack_status_next = ack_status_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        sc_next         = sc_reg;
        preds_next      = preds_reg;
        pidx_next       = pidx_reg;

        edge_we  = 1'b0;
        edge_re  = 1'b0;
        deg_re   = 1'b0;
        deg_we   = 1'b0;

        emit     = 1'b0;
        e_kind   = KIND_ACK;
        e_status = STATUS_OK;
        e_odeg   = '0;
        e_ideg   = '0;
        e_nb     = '0;
        e_last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    src_next        = req.edge_source;
                    dst_next        = req.edge_dest;
                    q_next          = req.query_vertex;
                    ack_kind_next   = KIND_ACK;
                    ack_status_next = STATUS_OK;
                    rem_next        = held_reg;
                    pend_next       = 1'b0;
                    sc_next         = '0;
                    preds_next      = '0;
                    pidx_next       = '0;
                    unique case (req.cmd)
                        CMD_ADD:
                        begin
                            // range check wins over the full check
                            if ({1'b0, req.edge_source} >= lim || {1'b0, req.edge_dest} >= lim)
                            begin
                                ack_status_next = STATUS_RANGE;
                                state_next      = ST_ACK;
                            end
                            else if (held_reg >= CNT_W'(MAX_EDGES))
                            begin
                                ack_status_next = STATUS_FULL;
                                state_next      = ST_ACK;
                            end
                            else
                            begin
                                state_next = ST_ADD_RD;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if ({1'b0, req.query_vertex} >= lim)
                            begin
                                ack_kind_next   = KIND_SUM;
                                ack_status_next = STATUS_RANGE;
                                state_next      = ST_ACK;
                            end
                            else
                            begin
                                state_next = ST_Q_PASS1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            held_next    = '0;
                            vld_out_next = '0;
                            vld_in_next  = '0;
                            state_next   = ST_ACK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD_RD:
            begin
                // append the edge, fetch both degree counts
                edge_we    = 1'b1;
                deg_re     = 1'b1;
                state_next = ST_ADD_WR;
            end

            ST_ADD_WR:
            begin
                deg_we                             = 1'b1;
                vld_out_next[src_reg[VIDX_W-1:0]]  = 1'b1;
                vld_in_next[dst_reg[VIDX_W-1:0]]   = 1'b1;
                held_next                          = held_reg + 1'b1;
                state_next                         = ST_ACK;
            end

            ST_ACK:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_kind     = ack_kind_reg;
                    e_status   = ack_status_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_Q_PASS1:
            begin
                // count successors and build the predecessor set, newest edge first
                deg_re = 1'b1;
                if (pend_reg)
                begin
                    preds_next = preds_scan;
                    if (hit.from_hit)
                    begin
                        sc_next = sc_reg + 1'b1;
                    end
                end
                if (rem_reg != '0)
                begin
                    edge_re   = 1'b1;
                    rem_next  = rem_m1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        rem_next   = held_reg;
                        state_next = ST_Q_SUM;
                    end
                end
            end

            ST_Q_SUM:
            begin
                if (slot_free)
                begin
                    emit     = 1'b1;
                    e_kind   = KIND_SUM;
                    e_odeg   = q_odeg;
                    e_ideg   = q_ideg;
                    e_last   = (sc_reg == '0) && (preds_reg == '0);
                    if (sc_reg != '0)
                    begin
                        state_next = ST_Q_PASS2;
                    end
                    else if (preds_reg != '0)
                    begin
                        state_next = ST_Q_PRED;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_Q_PASS2:
            begin
                // second walk emits successors; hold the fetched entry while stalled
                if (!(pend_reg && hit.from_hit && !slot_free))
                begin
                    if (pend_reg && hit.from_hit)
                    begin
                        emit    = 1'b1;
                        e_kind  = KIND_SUCC;
                        e_nb    = edge_rdata[VERT_W-1:0];
                        e_last  = (sc_reg == CNT_W'(1)) && (preds_reg == '0);
                        sc_next = sc_reg - 1'b1;
                    end
                    if (pend_reg && hit.from_hit && sc_reg == CNT_W'(1))
                    begin
                        pend_next  = 1'b0;
                        state_next = (preds_reg != '0) ? ST_Q_PRED : ST_IDLE;
                    end
                    else if (rem_reg != '0)
                    begin
                        edge_re   = 1'b1;
                        rem_next  = rem_m1;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            ST_Q_PRED:
            begin
                // ascending walk over the predecessor set
                if (preds_reg[pidx_reg])
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        e_kind     = KIND_PRED;
                        e_nb       = VERT_W'(pidx_reg);
                        e_last     = (preds_rest == '0);
                        preds_next = preds_rest;
                        pidx_next  = pidx_reg + 1'b1;
                        if (preds_rest == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    pidx_next = pidx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response register
    always_comb
    begin
        rv_next     = rv_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        odeg_next   = odeg_reg;
        ideg_next   = ideg_reg;
        nb_next     = nb_reg;
        last_next   = last_reg;
        if (emit)
        begin
            rv_next     = 1'b1;
            kind_next   = e_kind;
            status_next = e_status;
            odeg_next   = e_odeg;
            ideg_next   = e_ideg;
            nb_next     = e_nb;
            last_next   = e_last;
        end
        else if (rsp.ready)
        begin
            rv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vc_reg      <= VC_W'(MAX_VERTICES);
            held_reg    <= '0;
            vld_out_reg <= '0;
            vld_in_reg  <= '0;
            pend_reg    <= 1'b0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            vld_out_reg <= vld_out_next;
            vld_in_reg  <= vld_in_next;
            pend_reg    <= pend_next;
            rv_reg      <= rv_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    // payload and working registers, no reset
    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        q_reg          <= q_next;
        ack_kind_reg   <= ack_kind_next;
        ack_status_reg <= ack_status_next;
        rem_reg        <= rem_next;
        sc_reg         <= sc_next;
        preds_reg      <= preds_next;
        pidx_reg       <= pidx_next;
        kind_reg       <= kind_next;
        status_reg     <= status_next;
        odeg_reg       <= odeg_next;
        ideg_reg       <= ideg_next;
        nb_reg         <= nb_next;
        last_reg       <= last_next;
    end

    assign rsp.valid      = rv_reg;
    assign rsp.kind       = kind_reg;
    assign rsp.status     = status_reg;
    assign rsp.out_degree = odeg_reg;
    assign rsp.in_degree  = ideg_reg;
    assign rsp.neighbour  = nb_reg;
    assign rsp.last       = last_reg;

endmodule

@@ tb/directed_graph_edge_store_tb.sv @@
`timescale 1ns / 1ps

module directed_graph_edge_store_tb;
    import dges_pkg::*;

    // command code that the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // cycles without any accepted request or response before giving up
    localparam int STUCK_LIMIT = 4000;
    // extra wait after the last answer, before the next phase starts
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [VERT_W-1:0] src;
        logic [VERT_W-1:0] dst;
        logic [VERT_W-1:0] qv;
        bit                drain_first;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [DEG_W-1:0]  out_degree;
        logic [DEG_W-1:0]  in_degree;
        logic [VERT_W-1:0] neighbour;
        logic              last;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [VC_W-1:0] cfg_wdata;

    dges_req_if req_ch ();
    dges_rsp_if rsp_ch ();

    directed_graph_edge_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // stimulus waiting for the driver, answers waiting for the block
    request_t pending_requests[$];
    answer_t  answers_due[$];

    // shadow copy of the graph
    logic [VERT_W-1:0] arc_from [MAX_EDGES];
    logic [VERT_W-1:0] arc_to   [MAX_EDGES];
    int unsigned       arcs_held;
    logic [DEG_W-1:0]  out_deg  [MAX_VERTICES];
    logic [DEG_W-1:0]  in_deg   [MAX_VERTICES];
    int unsigned       vertex_limit;

    // limit the stimulus aims at, tracked by the sequencer
    int unsigned plan_limit;

    int  send_idle_pct;
    int  stall_pct;
    bit  req_taken;
    int  mismatches;
    int  stuck_cycles;

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic answer_t make_answer(input logic [KIND_W-1:0] kind,
                                            input logic [STAT_W-1:0] status,
                                            input logic [DEG_W-1:0]  od,
                                            input logic [DEG_W-1:0]  id,
                                            input logic [VERT_W-1:0] nb);
        answer_t a;
        a.kind       = kind;
        a.status     = status;
        a.out_degree = od;
        a.in_degree  = id;
        a.neighbour  = nb;
        a.last       = 1'b0;
        return a;
    endfunction

    // apply one accepted request to the shadow graph and queue its answers
    task automatic graph_response(input logic [CMD_W-1:0]  c,
                                  input logic [VERT_W-1:0] src,
                                  input logic [VERT_W-1:0] dst,
                                  input logic [VERT_W-1:0] q);
        answer_t batch[$];
        vset_t   preds;
        int      i;
        preds = '0;
        case (c)
            CMD_ADD:
            begin
                if (int'(src) >= vertex_limit || int'(dst) >= vertex_limit)
                    batch.push_back(make_answer(KIND_ACK, STATUS_RANGE, '0, '0, '0));
                else if (arcs_held >= MAX_EDGES)
                    batch.push_back(make_answer(KIND_ACK, STATUS_FULL, '0, '0, '0));
                else
                begin
                    arc_from[arcs_held] = src;
                    arc_to[arcs_held]   = dst;
                    arcs_held++;
                    out_deg[src]++;
                    in_deg[dst]++;
                    batch.push_back(make_answer(KIND_ACK, STATUS_OK, '0, '0, '0));
                end
            end
            CMD_QUERY:
            begin
                if (int'(q) >= vertex_limit)
                    batch.push_back(make_answer(KIND_SUM, STATUS_RANGE, '0, '0, '0));
                else
                begin
                    batch.push_back(make_answer(KIND_SUM, STATUS_OK, out_deg[q], in_deg[q],
                                                '0));
                    // newest edge first; predecessors collected from every held edge
                    for (i = int'(arcs_held); i > 0; i--)
                    begin
                        if (arc_from[i-1] == q)
                            batch.push_back(make_answer(KIND_SUCC, STATUS_OK, '0, '0,
                                                        arc_to[i-1]));
                        if (arc_to[i-1] == q)
                            preds[arc_from[i-1]] = 1'b1;
                    end
                    for (i = 0; i < MAX_VERTICES; i++)
                        if (preds[i])
                            batch.push_back(make_answer(KIND_PRED, STATUS_OK, '0, '0,
                                                        VERT_W'(i)));
                end
            end
            CMD_CLEAR:
            begin
                arcs_held = 0;
                for (i = 0; i < MAX_VERTICES; i++)
                begin
                    out_deg[i] = '0;
                    in_deg[i]  = '0;
                end
                batch.push_back(make_answer(KIND_ACK, STATUS_OK, '0, '0, '0));
            end
            default:
                ;   // unused code: nothing happens
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[k])
            answers_due.push_back(batch[k]);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s expected %0d got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // monitor: requests, responses and register writes seen at the rising edge
    always @(posedge clk)
    begin
        answer_t want;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
                vertex_limit = (cfg_wdata > MAX_VERTICES) ? MAX_VERTICES : cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                graph_response(req_ch.cmd, req_ch.edge_source, req_ch.edge_dest,
                               req_ch.query_vertex);
                req_taken = 1'b1;
                moved     = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (answers_due.size() == 0)
                begin
                    $error("response with nothing outstanding: kind %0d neighbour %0d",
                           rsp_ch.kind, rsp_ch.neighbour);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    check_field("kind", want.kind, rsp_ch.kind);
                    check_field("status", want.status, rsp_ch.status);
                    check_field("out_degree", want.out_degree, rsp_ch.out_degree);
                    check_field("in_degree", want.in_degree, rsp_ch.in_degree);
                    check_field("neighbour", want.neighbour, rsp_ch.neighbour);
                    check_field("last", want.last, rsp_ch.last);
                end
            end
        end
        // watchdog
        if (moved)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // driver: request channel and response back-pressure change on the falling edge
    always @(negedge clk)
    begin
        request_t nxt;
        bit       go;
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (!req_ch.valid || req_taken)
        begin
            req_taken = 1'b0;
            go = (pending_requests.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            // hold-off: wait for every outstanding answer before this request
            if (go && pending_requests[0].drain_first && answers_due.size() != 0)
                go = 1'b0;
            if (go)
            begin
                nxt = pending_requests.pop_front();
                req_ch.cmd          <= nxt.cmd;
                req_ch.edge_source  <= nxt.src;
                req_ch.edge_dest    <= nxt.dst;
                req_ch.query_vertex <= nxt.qv;
                req_ch.valid        <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // unused fields of each request get random values
    task automatic push_req(input logic [CMD_W-1:0] c, input int a, input int b,
                            input bit drain = 1'b0);
        request_t r;
        r.cmd         = c;
        r.src         = VERT_W'($urandom_range(15));
        r.dst         = VERT_W'($urandom_range(15));
        r.qv          = VERT_W'($urandom_range(15));
        r.drain_first = drain;
        if (c == CMD_ADD)
        begin
            r.src = VERT_W'(a);
            r.dst = VERT_W'(b);
        end
        else if (c == CMD_QUERY)
            r.qv = VERT_W'(a);
        pending_requests.push_back(r);
    endtask

    // mostly a vertex in range, now and then any vertex
    function automatic int pick_vertex();
        if (plan_limit == 0 || $urandom_range(9) == 0)
            return $urandom_range(15);
        return $urandom_range(plan_limit - 1);
    endfunction

    // well-formed build-and-query runs with random content, plus some noise
    task automatic queue_random(input int count);
        int made;
        int n_add;
        int n_q;
        int j;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(2) == 0)
                begin
                    push_req(CMD_CLEAR, 0, 0, $urandom_range(9) == 0);
                    made++;
                end
                n_add = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 10);
                for (j = 0; j < n_add; j++)
                    push_req(CMD_ADD, pick_vertex(), pick_vertex());
                n_q = $urandom_range(1, 4);
                for (j = 0; j < n_q; j++)
                    push_req(CMD_QUERY, pick_vertex(), 0);
                made += n_add + n_q;
            end
            else
            begin
                push_req(CMD_W'($urandom_range(3)), $urandom_range(15), $urandom_range(15));
                made++;
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 68;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 68;
            end
            default:
            begin
                send_idle_pct = 34;
                stall_pct     = 34;
            end
        endcase
    endtask

    // wait for every request to go and every answer to come, then let the block settle
    task automatic settle();
        @(negedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || answers_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_vertex_count(input int v);
        @(negedge clk);
        cfg_wdata <= VC_W'(v);
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        plan_limit = (v > MAX_VERTICES) ? MAX_VERTICES : v;
    endtask

    // sequencer
    initial
    begin
        int i;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_ADD;
        req_ch.edge_source  = '0;
        req_ch.edge_dest    = '0;
        req_ch.query_vertex = '0;
        rsp_ch.ready        = 1'b0;
        req_taken           = 1'b0;
        mismatches          = 0;
        stuck_cycles        = 0;
        arcs_held           = 0;
        vertex_limit        = MAX_VERTICES;
        plan_limit          = MAX_VERTICES;
        for (i = 0; i < MAX_VERTICES; i++)
        begin
            out_deg[i] = '0;
            in_deg[i]  = '0;
        end
        set_idling(0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset limit: extreme vertices, self loops, parallel edges, unused code
        push_req(CMD_CLEAR, 0, 0);
        push_req(CMD_ADD, 0, 15);
        push_req(CMD_ADD, 15, 0);
        push_req(CMD_ADD, 15, 15);
        push_req(CMD_ADD, 3, 3);
        push_req(CMD_ADD, 3, 3);
        push_req(CMD_ADD, 3, 9);
        push_req(CMD_ADD, 9, 3, 1'b1);
        push_req(CMD_QUERY, 3, 0);
        push_req(CMD_QUERY, 15, 0);
        push_req(CMD_QUERY, 0, 0);
        push_req(CMD_QUERY, 9, 0);
        push_req(CMD_UNUSED, $urandom_range(15), $urandom_range(15));
        push_req(CMD_QUERY, 7, 0);
        push_req(CMD_CLEAR, 0, 0);
        push_req(CMD_QUERY, 3, 0);
        settle();

        // no vertex valid at all
        write_vertex_count(0);
        set_idling(1);
        push_req(CMD_ADD, 0, 0);
        push_req(CMD_ADD, 15, 15);
        push_req(CMD_QUERY, 0, 0);
        push_req(CMD_QUERY, 15, 0);
        push_req(CMD_CLEAR, 0, 0);
        queue_random(20);
        settle();

        // register beyond the vertex count saturates
        write_vertex_count(31);
        set_idling(2);
        queue_random(60);
        push_req(CMD_CLEAR, 0, 0, 1'b1);
        push_req(CMD_ADD, 12, 2);
        push_req(CMD_ADD, 2, 13);
        settle();

        // shrunk vertex count: edges above the new limit are still reported
        write_vertex_count(5);
        set_idling(3);
        push_req(CMD_QUERY, 2, 0);
        push_req(CMD_QUERY, 12, 0);
        push_req(CMD_ADD, 6, 1);
        // fill the store, then full, then range beating full
        push_req(CMD_CLEAR, 0, 0);
        for (i = 0; i < MAX_EDGES; i++)
            push_req(CMD_ADD, (i % 3 == 0) ? 0 : $urandom_range(4), $urandom_range(4));
        push_req(CMD_ADD, 0, 1);
        push_req(CMD_ADD, 7, 1);
        push_req(CMD_QUERY, 0, 0);
        queue_random(50);
        settle();

        write_vertex_count(1);
        set_idling(0);
        push_req(CMD_QUERY, 0, 0);
        push_req(CMD_ADD, 0, 0);
        queue_random(40);
        settle();

        write_vertex_count(2);
        set_idling(1);
        queue_random(50);
        settle();

        write_vertex_count($urandom_range(31));
        set_idling(2);
        queue_random(50);
        settle();

        write_vertex_count(MAX_VERTICES);
        set_idling(3);
        queue_random(65);
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
